/* sv/fbes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbes_pkg
// Types and codes shared by the first-byte exchange sorter: the input and
// result words, one stored entry and the sequencer states.
// ----------------------------------------------------------------------------
package fbes_pkg;

  typedef struct packed {
    logic [7:0] first_byte;
    logic       last_item;
  } in_word_t;

  typedef struct packed {
    logic [3:0] arrival_index;
    logic [7:0] sorted_key;
    logic       final_result;
    logic       items_dropped;
  } out_word_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_SORT_RI,
    ST_SORT_LI,
    ST_SORT_RJ,
    ST_SORT_CJ,
    ST_SORT_WI,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

endpackage
`default_nettype wire

/* sv/first_byte_exchange_sort.sv */
`default_nettype none
// An item not marked last is taken while the sorter fills. After the last item
// the sort reads entry i, then for each later entry j reads and compares it on
// the entry memory (registered read), then writes entry i back; each result is
// read, loaded and held through any output stall. Input is stalled from the last
// item until the final result is taken. Reset clears control state, not data.
// ----------------------------------------------------------------------------
// first_byte_exchange_sort
// Batch sorter keyed on the first byte of a string: stores up to MAX_ITEMS
// words, exchange-sorts them with one shared comparator and emits them.
// ----------------------------------------------------------------------------
module first_byte_exchange_sort
  import fbes_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  entry_t          cur_r, cur_nxt;
  entry_t          rd_r;
  out_word_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  entry_t          mem [MAX_ITEMS];
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [AW-1:0]   raddr;

  logic [31:0]     count_ext;
  logic            in_acc;
  logic            out_acc;
  logic [CW-1:0]   cnt_after;

  assign count_ext = 32'(count_r);
  assign in_stall  = (state_r != ST_FILL);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata.idx     = count_ext[3:0];
    wdata.key     = in_word.first_byte;
    raddr         = i_r[AW-1:0];
    cnt_after     = count_r;

    case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_ITEMS)) begin
            we        = 1'b1;
            cnt_after = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = cnt_after;
          if (in_word.last_item) begin
            i_nxt = '0;
            k_nxt = '0;
            if (cnt_after < CW'(2)) begin
              state_nxt = ST_OUT_RD;
            end else begin
              state_nxt = ST_SORT_RI;
            end
          end
        end
      end
      ST_SORT_RI: begin
        raddr     = i_r[AW-1:0];
        state_nxt = ST_SORT_LI;
      end
      ST_SORT_LI: begin
        cur_nxt   = rd_r;
        j_nxt     = i_r + CW'(1);
        state_nxt = ST_SORT_RJ;
      end
      ST_SORT_RJ: begin
        raddr     = j_r[AW-1:0];
        state_nxt = ST_SORT_CJ;
      end
      ST_SORT_CJ: begin
        // swap: the held entry goes to j, j's entry is held
        if (cur_r.key > rd_r.key) begin
          we      = 1'b1;
          waddr   = j_r[AW-1:0];
          wdata   = cur_r;
          cur_nxt = rd_r;
        end
        j_nxt = j_r + CW'(1);
        if (j_r + CW'(1) == count_r) begin
          state_nxt = ST_SORT_WI;
        end else begin
          state_nxt = ST_SORT_RJ;
        end
      end
      ST_SORT_WI: begin
        we    = 1'b1;
        waddr = i_r[AW-1:0];
        wdata = cur_r;
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(2) >= count_r) begin
          state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = ST_SORT_RI;
        end
      end
      ST_OUT_RD: begin
        raddr     = k_r[AW-1:0];
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_nxt.arrival_index = rd_r.idx;
        out_nxt.sorted_key    = rd_r.key;
        out_nxt.final_result  = (k_r + CW'(1) == count_r);
        out_nxt.items_dropped = ovf_r;
        out_valid_nxt         = 1'b1;
        state_nxt             = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_r.final_result) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_FILL;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OUT_WAIT)
    else $error("result word valid outside output wait");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CW'(MAX_ITEMS))
    else $error("overflow flagged with room left");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SORT_CJ |-> (i_r < j_r) && (j_r < count_r))
    else $error("compare pair out of range");

  a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_r.final_result) |=> (state_r == ST_FILL) && (count_r == '0) && !ovf_r)
    else $error("batch not cleared after final word");

endmodule
`default_nettype wire

/* bench/first_byte_exchange_sort_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_byte_exchange_sort_checker
// Watches both channels of the sorter. It keeps its own copy of the batch
// being collected, sorts it the same way when the last word arrives, and
// checks each result word field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module first_byte_exchange_sort_checker
  import fbes_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending,
  output int        words_checked
);

  logic [7:0] batch_key [CAPACITY];
  logic [3:0] batch_idx [CAPACITY];
  int         batch_count = 0;
  bit         batch_overflow = 1'b0;
  out_word_t  sorted_expect [$];
  int         fails = 0;
  int         checked = 0;

  task automatic collect_word(input in_word_t w);
    logic [7:0] key_tmp;
    logic [3:0] idx_tmp;
    out_word_t  r;
    if (batch_count < CAPACITY) begin
      batch_key[batch_count] = w.first_byte;
      batch_idx[batch_count] = 4'(batch_count);
      batch_count++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (w.last_item) begin
      for (int a = 0; a + 1 < batch_count; a++) begin
        for (int b = a + 1; b < batch_count; b++) begin
          if (batch_key[a] > batch_key[b]) begin
            key_tmp      = batch_key[a];
            idx_tmp      = batch_idx[a];
            batch_key[a] = batch_key[b];
            batch_idx[a] = batch_idx[b];
            batch_key[b] = key_tmp;
            batch_idx[b] = idx_tmp;
          end
        end
      end
      for (int k = 0; k < batch_count; k++) begin
        r.arrival_index = batch_idx[k];
        r.sorted_key    = batch_key[k];
        r.final_result  = (k + 1 == batch_count);
        r.items_dropped = batch_overflow;
        sorted_expect.push_back(r);
      end
      batch_count    = 0;
      batch_overflow = 1'b0;
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (sorted_expect.size() == 0) begin
      $error("result word with none expected: index %0d key %0h", got.arrival_index,
             got.sorted_key);
      fails++;
    end else begin
      want = sorted_expect.pop_front();
      checked++;
      if (got.arrival_index !== want.arrival_index) begin
        $error("arrival_index expected %0d actual %0d", want.arrival_index,
               got.arrival_index);
        fails++;
      end
      if (got.sorted_key !== want.sorted_key) begin
        $error("sorted_key expected %0h actual %0h", want.sorted_key, got.sorted_key);
        fails++;
      end
      if (got.final_result !== want.final_result) begin
        $error("final_result expected %0b actual %0b", want.final_result,
               got.final_result);
        fails++;
      end
      if (got.items_dropped !== want.items_dropped) begin
        $error("items_dropped expected %0b actual %0b", want.items_dropped,
               got.items_dropped);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      batch_count    = 0;
      batch_overflow = 1'b0;
      sorted_expect.delete();
    end else begin
      if (out_valid && !out_stall) check_word(out_word);
      if (in_valid && !in_stall) collect_word(in_word);
    end
    fail_count    <= fails;
    pending       <= sorted_expect.size();
    words_checked <= checked;
  end

endmodule

/* bench/first_byte_exchange_sort_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_byte_exchange_sort_tb
// Feeds batches of keys to the sorter: a few fixed batches covering extreme
// keys, equal keys and an overflowing batch, then random batches with random
// gaps and output stalls, one long output hold-off and a calm stretch.
// ----------------------------------------------------------------------------
module first_byte_exchange_sort_tb
  import fbes_pkg::*;
();

  localparam int MAX_ITEMS    = 16;
  localparam int RANDOM_ITEMS = 186;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int fail_count;
  int pending;
  int words_checked;
  int items_sent   = 0;
  int batches_sent = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit squeeze      = 1'b0;

  first_byte_exchange_sort #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  first_byte_exchange_sort_checker #(
    .CAPACITY(MAX_ITEMS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .fail_count   (fail_count),
    .pending      (pending),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("first_byte_exchange_sort_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off once asked for
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 19);
      end
    end
  end

  task automatic send_word(input logic [7:0] key, input logic last);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      in_word  <= in_word_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{first_byte: key, last_item: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (last) batches_sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int n_batch;
    int size;
    bit narrow;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single word batch
    send_word(8'h00, 1'b1);
    // extreme and equal keys
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b1);
    // full batch, then a dropped word and a dropped last word
    for (int k = 0; k < MAX_ITEMS; k++) send_word(8'(k * 37 + 5), 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h00, 1'b1);

    n_batch = 0;
    while (items_sent < 24 + RANDOM_ITEMS) begin
      if (n_batch == 2) squeeze = 1'b1;
      calm = (n_batch >= 6 && n_batch < 11);
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
        1:       size = $urandom_range(1, 2);
        default: size = $urandom_range(1, MAX_ITEMS);
      endcase
      if (n_batch == 2) size = MAX_ITEMS;
      narrow = 1'($urandom_range(0, 1));
      for (int k = 0; k < size; k++) begin
        send_word(narrow ? 8'($urandom_range(0, 3)) - 8'd1 : 8'($urandom), k == size - 1);
      end
      n_batch++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words in %0d batches, checked %0d result words", items_sent,
             batches_sent, words_checked);
    $display("covered overflowing batches, repeated keys and a long output hold-off");
    if (fail_count == 0) begin
      $display("first_byte_exchange_sort_tb passed");
    end else begin
      $display("first_byte_exchange_sort_tb failed");
    end
    $finish;
  end

endmodule
